// ----- sv/stt_pkg.sv -----
// package for the sparse triplet table: entry layout, sizes and codes
// used by sparse_triplet_table; depends on nothing else
package stt_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned MaxRows    = 16;
  localparam int unsigned MaxCols    = 16;

  localparam int unsigned AddrW  = $clog2(TableDepth);
  localparam int unsigned CountW = $clog2(TableDepth + 1);
  localparam int unsigned RowW   = 4;
  localparam int unsigned ColW   = 4;
  localparam int unsigned ValW   = 32;
  localparam int unsigned DimW   = 5;
  localparam int unsigned EntryW = RowW + ColW + ValW;

  typedef enum logic [1:0] {
    FuncClear = 2'd0,
    FuncLoad  = 2'd1,
    FuncSet   = 2'd2,
    FuncGet   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  localparam logic RegRowCount = 1'b0;
  localparam logic RegColCount = 1'b1;

  localparam logic [DimW-1:0] RowCountReset = 5'd10;
  localparam logic [DimW-1:0] ColCountReset = 5'd10;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [ValW-1:0] val;
  } entry_t;

endpackage

// ----- sv/sparse_triplet_table.sv -----
// sparse matrix kept as a sorted (row, column, value) list in one synchronous ram
// depends on stt_pkg
//
// usage: a command is taken when start is high and busy is low; func_i selects
// clear, load, set or get on (row_index_i, col_index_i) with data_value_i.
// exactly one result per command: done_o is high for one cycle with status_o,
// read_value_o and entry_total_o; the receiver cannot stall, so each result
// must be taken in that cycle.
// steps from accept to done_o:
//   clear, load, out-of-range: done_o in the cycle after accept
//   get: a search that steps over the smaller entries, then done_o
//   set: a search, then done_o on an update or an append at the end; when
//        entries move up by one, the shift from the top down, then the insert
//   search steps plus moved entries never exceed the entry count
// the single entry ram sets the pace: the search reads one entry per
// cycle, and the shift moves one entry per cycle (read m-1, write m).
// one command at a time: busy drops in the cycle done_o is high.
// reset empties the table (count to zero, ram contents left as they are) and
// sets row_count and col_count to 10; no clearing pass is needed.
// configuration: apb, row_count at 0x0, col_count at 0x4, write only while idle.
module sparse_triplet_table
  import stt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             func_i,
  input  logic [RowW-1:0]        row_index_i,
  input  logic [ColW-1:0]        col_index_i,
  input  logic signed [ValW-1:0] data_value_i,
  // result channel
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic signed [ValW-1:0] read_value_o,
  output logic [CountW-1:0]      entry_total_o,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StShift,
    StInsert
  } state_e;

  state_e               state_q;
  logic [DimW-1:0]      row_count_q, col_count_q;
  logic [CountW-1:0]    entry_count_q;
  logic [CountW-1:0]    k_q, m_q;
  logic                 ph2_q;
  func_e                func_q;
  logic [RowW-1:0]      row_q;
  logic [ColW-1:0]      col_q;
  logic [ValW-1:0]      val_q;
  logic                 done_q;
  status_e              status_q;
  logic [ValW-1:0]      rd_q;
  logic [CountW-1:0]    total_q;

  logic [EntryW-1:0]    entry_mem [TableDepth];
  logic [EntryW-1:0]    rdata_q;
  logic [AddrW-1:0]     raddr;
  logic [AddrW-1:0]     waddr;
  logic [EntryW-1:0]    wdata;
  logic                 mem_we;

  entry_t               rd_entry;
  func_e                func_in;
  logic                 accept, in_range, full, at_end;
  logic                 row_gt, row_eq, col_gt, col_eq, skip, hit;
  logic [CountW-1:0]    k_inc, cnt_inc, cnt_dec, m_dec, m_dec2;
  logic                 cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountReset;
      col_count_q <= ColCountReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegRowCount: row_count_q <= pwdata[DimW-1:0];
        RegColCount: col_count_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegRowCount: prdata = {{(32-DimW){1'b0}}, row_count_q};
      RegColCount: prdata = {{(32-DimW){1'b0}}, col_count_q};
      default:     prdata = '0;
    endcase
  end

  // entry ram, one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[waddr] <= wdata;
    end
    rdata_q <= entry_mem[raddr];
  end

  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  assign func_in  = func_e'(func_i);
  assign in_range = ({1'b0, row_index_i} < row_count_q) &&
                    ({1'b0, row_index_i} < DimW'(MaxRows)) &&
                    ({1'b0, col_index_i} < col_count_q) &&
                    ({1'b0, col_index_i} < DimW'(MaxCols));
  assign full     = (entry_count_q >= CountW'(TableDepth));

  assign k_inc   = k_q + CountW'(1);
  assign cnt_inc = entry_count_q + CountW'(1);
  assign cnt_dec = entry_count_q - CountW'(1);
  assign m_dec   = m_q - CountW'(1);
  assign m_dec2  = m_q - CountW'(2);

  // two-phase scan: first skip smaller rows, then smaller columns in the row
  always_comb begin
    rd_entry = entry_t'(rdata_q);
    at_end   = (k_q == entry_count_q);
    row_gt   = (row_q > rd_entry.row);
    row_eq   = (row_q == rd_entry.row);
    col_gt   = (col_q > rd_entry.col);
    col_eq   = (col_q == rd_entry.col);
    skip     = !at_end && ((!ph2_q && row_gt) || (row_eq && col_gt));
    hit      = !at_end && row_eq && col_eq;
  end

  // ram address and write control
  always_comb begin
    raddr  = '0;
    mem_we = 1'b0;
    waddr  = k_q[AddrW-1:0];
    wdata  = {row_q, col_q, val_q};
    case (state_q)
      StIdle: begin
        if (accept && in_range && func_in == FuncLoad &&
            data_value_i != '0 && !full) begin
          mem_we = 1'b1;
          waddr  = entry_count_q[AddrW-1:0];
          wdata  = {row_index_i, col_index_i, data_value_i};
        end
      end
      StSearch: begin
        if (skip) begin
          raddr = k_inc[AddrW-1:0];
        end else if (func_q == FuncSet) begin
          if (hit) begin
            mem_we = 1'b1;
          end else if (!full) begin
            if (at_end) begin
              mem_we = 1'b1;
            end else begin
              raddr = cnt_dec[AddrW-1:0];
            end
          end
        end
      end
      StShift: begin
        mem_we = 1'b1;
        waddr  = m_q[AddrW-1:0];
        wdata  = rdata_q;
        raddr  = m_dec2[AddrW-1:0];
      end
      StInsert: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      entry_count_q <= '0;
      k_q           <= '0;
      m_q           <= '0;
      ph2_q         <= 1'b0;
      func_q        <= FuncClear;
      row_q         <= '0;
      col_q         <= '0;
      val_q         <= '0;
      done_q        <= 1'b0;
      status_q      <= StatusOk;
      rd_q          <= '0;
      total_q       <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            func_q <= func_in;
            row_q  <= row_index_i;
            col_q  <= col_index_i;
            val_q  <= data_value_i;
            k_q    <= '0;
            ph2_q  <= 1'b0;
            rd_q   <= '0;
            if (func_in == FuncClear) begin
              entry_count_q <= '0;
              done_q        <= 1'b1;
              status_q      <= StatusOk;
              total_q       <= '0;
            end else if (!in_range) begin
              done_q   <= 1'b1;
              status_q <= StatusRange;
              total_q  <= entry_count_q;
            end else if (func_in == FuncLoad) begin
              done_q <= 1'b1;
              if (data_value_i == '0) begin
                status_q <= StatusOk;
                total_q  <= entry_count_q;
              end else if (full) begin
                status_q <= StatusFull;
                total_q  <= entry_count_q;
              end else begin
                status_q      <= StatusOk;
                entry_count_q <= cnt_inc;
                total_q       <= cnt_inc;
              end
            end else begin
              state_q <= StSearch;
            end
          end
        end
        StSearch: begin
          if (skip) begin
            k_q   <= k_inc;
            ph2_q <= ph2_q || !row_gt;
          end else if (func_q == FuncGet) begin
            state_q  <= StIdle;
            done_q   <= 1'b1;
            status_q <= StatusOk;
            rd_q     <= hit ? rd_entry.val : '0;
            total_q  <= entry_count_q;
          end else if (hit) begin
            state_q  <= StIdle;
            done_q   <= 1'b1;
            status_q <= StatusOk;
            total_q  <= entry_count_q;
          end else if (full) begin
            state_q  <= StIdle;
            done_q   <= 1'b1;
            status_q <= StatusFull;
            total_q  <= entry_count_q;
          end else if (at_end) begin
            state_q       <= StIdle;
            done_q        <= 1'b1;
            status_q      <= StatusOk;
            entry_count_q <= cnt_inc;
            total_q       <= cnt_inc;
          end else begin
            state_q <= StShift;
            m_q     <= entry_count_q;
          end
        end
        StShift: begin
          // entry m-1 moves to m; stop once the insert slot is vacated
          if (m_dec == k_q) begin
            state_q <= StInsert;
          end else begin
            m_q <= m_dec;
          end
        end
        StInsert: begin
          state_q       <= StIdle;
          done_q        <= 1'b1;
          status_q      <= StatusOk;
          entry_count_q <= cnt_inc;
          total_q       <= cnt_inc;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rd_q;
  assign entry_total_o = total_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CountW'(TableDepth))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_count_q != $past(entry_count_q)) |->
      (entry_count_q == $past(cnt_inc) || entry_count_q == '0))
    else $error("entry count moved by more than one");

  a_shift_above_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |-> (m_q > k_q && m_q <= entry_count_q))
    else $error("shift pointer outside its range");

  a_read_only_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != StatusOk || func_q != FuncGet)) |-> (read_value_o == '0))
    else $error("read value on a transaction that is not a get");

  a_search_within: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |-> (k_q <= entry_count_q))
    else $error("search ran past the last entry");
`endif

endmodule
